// ===== hdl/distinct_first_counting_sort_core_assert.svh =====
// Assertion macros for the distinct-first counting sort core.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef DISTINCT_FIRST_COUNTING_SORT_CORE_ASSERT_SVH
`define DISTINCT_FIRST_COUNTING_SORT_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DFCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("distinct_first_counting_sort_core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DFCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("distinct_first_counting_sort_core: next-cycle check failed");

`else

`define DFCS_ASSERT_IMP(lbl, ante, cons)
`define DFCS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hdl/dfcs_pkg.sv =====
`timescale 1ns / 1ps

package dfcs_pkg;

  // Width of one element of the set.
  localparam int VALUE_W = 7;
  // Width of a histogram count and of the item counter.
  localparam int CNT_W   = 7;
  // Width of the tdata bus on both channels: one element, padded to a whole byte.
  localparam int TDATA_W = 8;

  // Operations of the shared count unit.
  typedef enum logic {
    ALU_INC,
    ALU_DEC
  } alu_op_t;

  // Result of the shared count unit.
  typedef struct packed {
    logic [CNT_W-1:0] y;     // result of the operation
    logic             zero;  // set when the operand is zero
  } alu_res_t;

endpackage

// ===== hdl/dfcs_ram.sv =====
`timescale 1ns / 1ps

module dfcs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/dfcs_alu.sv =====
`timescale 1ns / 1ps

module dfcs_alu (
  input  dfcs_pkg::alu_op_t           op,
  input  logic [dfcs_pkg::CNT_W-1:0]  a,
  output dfcs_pkg::alu_res_t          res
);

  import dfcs_pkg::*;

  // One incrementer/decrementer with a zero test on the operand, shared by the
  // histogram update, the bin inspection and the copy countdown.
  always_comb begin
    res.zero = (a == '0);
    unique case (op)
      ALU_INC: res.y = a + CNT_W'(1);
      ALU_DEC: res.y = a - CNT_W'(1);
      default: res.y = a;
    endcase
  end

endmodule

// ===== hdl/distinct_first_counting_sort_core.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Ports                           | Contents
// in_     | slave     | tvalid tready tdata tlast       | set element, tlast closes the set
// out_    | master    | tvalid tready tdata tlast tuser | sorted element, end of run, overflow
//
// Loading an element reads its bin, then writes the incremented count back.
// The emit walks the bins twice, checking each bin and then giving out its copies.
// Synchronous active-low reset clears the control state and every bin valid bit at once.
// A result waits in the output register while out_tready is low and the walk stalls;
// in_tready is high only while the block waits for a request.

module distinct_first_counting_sort_core #(
  parameter int MAX_ITEMS   = 64,
  parameter int VALUE_RANGE = 128
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [dfcs_pkg::TDATA_W-1:0]  in_tdata,   // [6:0] value, [7] zero
  input  logic                          in_tlast,   // is_last
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dfcs_pkg::TDATA_W-1:0]  out_tdata,  // [6:0] value_res, [7] zero
  output logic                          out_tlast,  // is_last_res
  output logic                          out_tuser   // [0] overflow
);

  import dfcs_pkg::*;

`include "distinct_first_counting_sort_core_assert.svh"

  // Only values that fit in the element field can ever be counted, so the store
  // never needs more than 2^VALUE_W bins.
  localparam int NB = (VALUE_RANGE < (1 << VALUE_W)) ? VALUE_RANGE : (1 << VALUE_W);
  localparam int AW = $clog2(NB);
  localparam logic [VALUE_W:0]   NB_L     = (VALUE_W + 1)'(NB);
  localparam logic [CNT_W-1:0]   MAX_L    = CNT_W'(MAX_ITEMS);
  localparam logic [AW-1:0]      LAST_BIN = AW'(NB - 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_LD_WR    = 3'd1;
  localparam logic [2:0] S_EM_START = 3'd2;
  localparam logic [2:0] S_EMPTY    = 3'd3;
  localparam logic [2:0] S_EM_CHK   = 3'd4;
  localparam logic [2:0] S_EM_OUT   = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   item_count_r, item_count_nxt;
  logic               dropped_r, dropped_nxt;
  logic               last_r, last_nxt;
  logic [AW-1:0]      ld_addr_r, ld_addr_nxt;
  logic [AW-1:0]      bin_r, bin_nxt;
  logic               phase_r, phase_nxt;
  logic [CNT_W-1:0]   rep_r, rep_nxt;
  logic [NB-1:0]      valid_r, valid_nxt;

  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_last_r;
  logic               out_ovf_r;

  logic [VALUE_W-1:0] in_value;
  logic [AW-1:0]      in_addr;
  logic               in_range;
  logic               full;
  logic               in_drop;
  logic               slot_free;

  logic               ram_we;
  logic [AW-1:0]      ram_raddr;
  logic [CNT_W-1:0]   ram_rdata;
  logic [AW-1:0]      rd_idx;
  logic [CNT_W-1:0]   cnt_now;

  alu_op_t            alu_op;
  logic [CNT_W-1:0]   alu_a;
  alu_res_t           alu_res;

  logic               emit;
  logic [VALUE_W-1:0] emit_value;
  logic               emit_last;

  assign in_value  = in_tdata[VALUE_W-1:0];
  assign in_addr   = in_value[AW-1:0];
  assign in_range  = ({1'b0, in_value} < NB_L);
  assign full      = (item_count_r >= MAX_L);
  assign in_drop   = !in_range || full;
  assign slot_free = !out_valid_r || out_tready;

  // A bin whose valid bit is clear has not been written since the last set and
  // reads as zero, whatever the memory holds.
  assign rd_idx  = (state_r == S_LD_WR) ? ld_addr_r : bin_r;
  assign cnt_now = valid_r[rd_idx] ? ram_rdata : '0;

  // The shared unit increments on a load write-back, and otherwise decrements
  // either the bin count just read or the copies still to be given.
  assign alu_op = (state_r == S_LD_WR) ? ALU_INC : ALU_DEC;
  assign alu_a  = (state_r == S_EM_OUT) ? rep_r : cnt_now;

  dfcs_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .res (alu_res)
  );

  dfcs_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NB)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_addr_r),
    .wdata (alu_res.y),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    item_count_nxt = item_count_r;
    dropped_nxt    = dropped_r;
    last_nxt       = last_r;
    ld_addr_nxt    = ld_addr_r;
    bin_nxt        = bin_r;
    phase_nxt      = phase_r;
    rep_nxt        = rep_r;
    valid_nxt      = valid_r;
    ram_we         = 1'b0;
    emit           = 1'b0;
    emit_value     = '0;
    emit_last      = 1'b0;
    in_tready      = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_drop) begin
            // Start the read of this element's bin; the count comes back next cycle.
            ld_addr_nxt = in_addr;
            last_nxt    = in_tlast;
            state_nxt   = S_LD_WR;
          end else begin
            // An element that cannot be counted is dropped, but its end mark still counts.
            dropped_nxt = 1'b1;
            if (in_tlast) begin
              state_nxt = S_EM_START;
            end
          end
        end
      end
      S_LD_WR: begin
        ram_we               = 1'b1;
        valid_nxt[ld_addr_r] = 1'b1;
        item_count_nxt       = item_count_r + CNT_W'(1);
        state_nxt            = last_r ? S_EM_START : S_IDLE;
      end
      S_EM_START: begin
        phase_nxt = 1'b0;
        bin_nxt   = '0;
        state_nxt = (item_count_r == '0) ? S_EMPTY : S_EM_CHK;
      end
      S_EMPTY: begin
        // A set with no counted element still yields a single closing result.
        if (slot_free) begin
          emit        = 1'b1;
          emit_last   = 1'b1;
          dropped_nxt = 1'b0;
          state_nxt   = S_IDLE;
        end
      end
      S_EM_CHK: begin
        // The distinct walk gives one copy of a present value; the remainder walk
        // gives the others, so it owes one fewer than the count.
        if (alu_res.zero) begin
          rep_nxt = '0;
        end else if (phase_r) begin
          rep_nxt = alu_res.y;
        end else begin
          rep_nxt = CNT_W'(1);
        end
        state_nxt = S_EM_OUT;
      end
      S_EM_OUT: begin
        if (alu_res.zero) begin
          if (bin_r == LAST_BIN) begin
            if (!phase_r) begin
              phase_nxt = 1'b1;
              bin_nxt   = '0;
              state_nxt = S_EM_CHK;
            end else begin
              // Every copy has gone out: forget the whole histogram at once.
              valid_nxt   = '0;
              dropped_nxt = 1'b0;
              state_nxt   = S_IDLE;
            end
          end else begin
            bin_nxt   = bin_r + AW'(1);
            state_nxt = S_EM_CHK;
          end
        end else if (slot_free) begin
          emit                  = 1'b1;
          emit_value[AW-1:0]    = bin_r;
          emit_last             = (item_count_r == CNT_W'(1));
          item_count_nxt        = item_count_r - CNT_W'(1);
          rep_nxt               = alu_res.y;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // While waiting for a request the memory looks up the incoming element's bin;
    // during the emit it looks up the bin that the walk moves to.
    ram_raddr = (state_r == S_IDLE) ? in_addr : bin_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      item_count_r <= '0;
      dropped_r    <= 1'b0;
      last_r       <= 1'b0;
      phase_r      <= 1'b0;
      valid_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      item_count_r <= item_count_nxt;
      dropped_r    <= dropped_nxt;
      last_r       <= last_nxt;
      phase_r      <= phase_nxt;
      valid_r      <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ld_addr_r <= ld_addr_nxt;
    bin_r     <= bin_nxt;
    rep_r     <= rep_nxt;
  end

  // Output register: a new result is loaded only when the previous one has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value_r <= emit_value;
      out_last_r  <= emit_last;
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W - VALUE_W){1'b0}}, out_value_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // The result that closes a run must leave no counted element behind.
  `DFCS_ASSERT_NXT(a_last_drains_count, emit && emit_last, item_count_r == '0)
  // A dropped element must not change the number of counted elements.
  `DFCS_ASSERT_NXT(a_drop_keeps_count, in_tvalid && in_tready && in_drop, $stable(item_count_r))
  // The counter never passes the set limit while requests are taken.
  `DFCS_ASSERT_IMP(a_count_bounded, state_r == S_IDLE, item_count_r <= MAX_L)

endmodule
